@@ hw/rtl/cpb_pkg.sv @@
// Shared constants and codes for the clipped pixel blit with format conversion.
// Used by cpb_format and by clipped_pixel_blit_format_convert_core.
package cpb_pkg;

  // Fixed field widths
  localparam int FB_DIM_W   = 13;
  localparam int LINE_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int ADDR_W     = 26;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int XBYTES_W   = FB_DIM_W + 2;

  // Parameter defaults
  localparam int MAX_DIM_DEF        = 4096;
  localparam int MAX_LINE_BYTES_DEF = 16384;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd7;

  // Depth codes
  localparam logic [1:0] DEPTH_16   = 2'd0;
  localparam logic [1:0] DEPTH_24   = 2'd1;
  localparam logic [1:0] DEPTH_32   = 2'd2;
  localparam logic [1:0] DEPTH_NONE = 2'd3;

  // Color codes
  localparam logic COLOR_GRAY = 1'b0;
  localparam logic COLOR_RGB  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [FB_DIM_W-1:0] FB_WIDTH_RST    = 13'd640;
  localparam logic [FB_DIM_W-1:0] FB_HEIGHT_RST   = 13'd480;
  localparam logic [LINE_W-1:0]   LINE_LENGTH_RST = 15'd2560;
  localparam logic [1:0]          DEPTH_MODE_RST  = DEPTH_32;
  localparam logic [FB_DIM_W-1:0] SRC_WIDTH_RST   = 13'd640;
  localparam logic                COLOR_MODE_RST  = COLOR_RGB;

  // One placed pixel waiting for format conversion
  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [FB_DIM_W-1:0] fx;
  } cpb_pixel_t;

  // Converted pixel: word, byte count and column byte offset
  typedef struct packed {
    logic [WORD_W-1:0]   pixel_word;
    logic [COUNT_W-1:0]  byte_count;
    logic [XBYTES_W-1:0] x_bytes;
  } cpb_format_t;

endpackage

@@ hw/rtl/cpb_format.sv @@
// Pixel format conversion: gray expansion, RGB565 / 24 bpp / 32 bpp packing,
// and column byte offset. Depends on cpb_pkg.
module cpb_format (
  input  logic [1:0]         depth_mode,
  input  logic               color_mode,
  input  cpb_pkg::cpb_pixel_t pix,
  output cpb_pkg::cpb_format_t fmt
);
  import cpb_pkg::*;

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [XBYTES_W-1:0] fx_ext;

  assign r      = pix.red;
  assign g      = (color_mode == COLOR_GRAY) ? pix.red : pix.green;
  assign b      = (color_mode == COLOR_GRAY) ? pix.red : pix.blue;
  assign fx_ext = XBYTES_W'(pix.fx);

  always_comb begin
    unique case (depth_mode)
      DEPTH_16: begin
        fmt.pixel_word = {16'd0, r[7:3], g[7:2], b[7:3]};
        fmt.byte_count = 3'd2;
        fmt.x_bytes    = fx_ext << 1;
      end
      DEPTH_24: begin
        fmt.pixel_word = {8'd0, r, g, b};
        fmt.byte_count = 3'd3;
        fmt.x_bytes    = fx_ext + (fx_ext << 1);
      end
      default: begin
        // 32 bpp; unsupported depth never reaches the output
        fmt.pixel_word = {8'hFF, r, g, b};
        fmt.byte_count = 3'd4;
        fmt.x_bytes    = fx_ext << 2;
      end
    endcase
  end

endmodule

@@ hw/rtl/clipped_pixel_blit_format_convert_core.sv @@
// Top level of the clipped pixel blit: stream in, placement and clipping,
// address and word out. Depends on cpb_pkg and cpb_format.
//
// Source pixels arrive in raster order, one per transfer, with tlast on the
// last pixel of a frame. Each pixel is placed at column/row plus the signed
// offsets; pixels outside the framebuffer, or any pixel when depth_mode is 3,
// produce no output. Throughput is one pixel per clock while the output is
// not stalled. An input stage does placement and clipping, and a result
// stage does the single line_length times row multiply and the format
// packing. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle, which it does not enforce.
module clipped_pixel_blit_format_convert_core #(
  parameter int MAX_DIM        = cpb_pkg::MAX_DIM_DEF,
  parameter int MAX_LINE_BYTES = cpb_pkg::MAX_LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // red, green, blue
  input  logic                           s_tlast,   // end_of_frame
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [63:0]                    m_tdata    // byte_address, pixel_word, byte_count
);
  import cpb_pkg::*;

  localparam int CW  = $clog2(MAX_DIM);
  localparam int NW  = ((CW + 1) > FB_DIM_W) ? (CW + 1) : FB_DIM_W;
  localparam int SW  = ((CW > FB_DIM_W) ? CW : FB_DIM_W) + 2;
  localparam int LLW = $clog2(MAX_LINE_BYTES + 1);
  localparam int LCW = (LLW > LINE_W) ? LLW : LINE_W;
  localparam int PW  = LCW + FB_DIM_W;

  // Configuration
  logic [FB_DIM_W-1:0] fb_width;
  logic [FB_DIM_W-1:0] fb_height;
  logic [LINE_W-1:0]   line_length;
  logic [1:0]          depth_mode;
  logic [FB_DIM_W-1:0] x_offset;
  logic [FB_DIM_W-1:0] y_offset;
  logic [FB_DIM_W-1:0] src_width;
  logic                color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width    <= FB_WIDTH_RST;
      fb_height   <= FB_HEIGHT_RST;
      line_length <= LINE_LENGTH_RST;
      depth_mode  <= DEPTH_MODE_RST;
      x_offset    <= '0;
      y_offset    <= '0;
      src_width   <= SRC_WIDTH_RST;
      color_mode  <= COLOR_MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FB_WIDTH:    fb_width    <= cfg_data[FB_DIM_W-1:0];
        REG_FB_HEIGHT:   fb_height   <= cfg_data[FB_DIM_W-1:0];
        REG_LINE_LENGTH: line_length <= cfg_data[LINE_W-1:0];
        REG_DEPTH_MODE:  depth_mode  <= cfg_data[1:0];
        REG_X_OFFSET:    x_offset    <= cfg_data[FB_DIM_W-1:0];
        REG_Y_OFFSET:    y_offset    <= cfg_data[FB_DIM_W-1:0];
        REG_SRC_WIDTH:   src_width   <= cfg_data[FB_DIM_W-1:0];
        REG_COLOR_MODE:  color_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_xfer;
  logic a_valid;
  logic a_write;
  logic a_move;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign a_move   = a_valid && out_free;
  assign s_tready = !a_valid || out_free;
  assign in_xfer  = s_tvalid && s_tready;

  // Source position counters
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [NW-1:0] col_inc;
  logic [NW-1:0] row_inc;
  logic          col_wrap;

  assign col_inc  = NW'(column_count) + NW'(1);
  assign row_inc  = NW'(row_count) + NW'(1);
  assign col_wrap = (col_inc >= NW'(src_width)) || (col_inc >= NW'(MAX_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (col_wrap) begin
        column_count <= '0;
        row_count    <= (row_inc >= NW'(MAX_DIM)) ? '0 : row_inc[CW-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  // Placement and clipping
  logic [SW-1:0] fx;
  logic [SW-1:0] fy;
  logic          on_fb;

  assign fx = {{(SW - FB_DIM_W){x_offset[FB_DIM_W-1]}}, x_offset} + SW'(column_count);
  assign fy = {{(SW - FB_DIM_W){y_offset[FB_DIM_W-1]}}, y_offset} + SW'(row_count);
  assign on_fb = !fx[SW-1] && !fy[SW-1] &&
                 (fx < SW'(fb_width)) && (fy < SW'(fb_height));

  // Input stage
  cpb_pixel_t          a_pix;
  logic [FB_DIM_W-1:0] a_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_xfer) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_write     <= on_fb && (depth_mode != DEPTH_NONE);
      a_pix.red   <= s_tdata[7:0];
      a_pix.green <= s_tdata[15:8];
      a_pix.blue  <= s_tdata[23:16];
      a_pix.fx    <= fx[FB_DIM_W-1:0];
      a_fy        <= fy[FB_DIM_W-1:0];
    end
  end

  // Result stage
  cpb_format_t    fmt;
  logic [LCW-1:0] ll;
  logic [PW-1:0]  row_addr;
  logic [PW:0]    addr_sum;

  cpb_format u_format (
    .depth_mode (depth_mode),
    .color_mode (color_mode),
    .pix        (a_pix),
    .fmt        (fmt)
  );

  assign ll       = (LCW'(line_length) > LCW'(MAX_LINE_BYTES)) ? LCW'(MAX_LINE_BYTES)
                                                               : LCW'(line_length);
  assign row_addr = PW'(ll) * PW'(a_fy);
  assign addr_sum = (PW + 1)'(row_addr) + (PW + 1)'(fmt.x_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= a_valid && a_write;
    end
  end

  // Hold the result while the downstream side stalls
  always_ff @(posedge clk) begin
    if (a_move) begin
      m_tdata <= {3'd0, fmt.byte_count, fmt.pixel_word, addr_sum[ADDR_W-1:0]};
    end
  end

endmodule

@@ test/cpb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the clipped pixel blit: predicts framebuffer writes from the pixel stream.
// Compares them with the master-side transfers. Depends on cpb_pkg.
module cpb_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // red, green, blue
  input  logic                           s_tlast,   // end_of_frame
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [63:0]                    m_tdata,   // byte_address, pixel_word, byte_count
  output int                             mismatches,
  output int                             pending,
  output int                             writes_checked
);
  import cpb_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0]  byte_address;
    logic [WORD_W-1:0]  pixel_word;
    logic [COUNT_W-1:0] byte_count;
  } fb_write_t;

  fb_write_t expected_writes[$];

  logic [FB_DIM_W-1:0] fb_width, fb_height, x_offset, y_offset, src_width;
  logic [LINE_W-1:0]   line_length;
  logic [1:0]          depth_mode;
  logic                color_mode;
  logic [11:0]         column, row_idx;
  int                  error_total, checked_total;

  initial begin
    error_total    = 0;
    checked_total  = 0;
  end

  // Place one source pixel, queue its write if it lands inside, then advance the counters.
  function automatic void place_pixel(input logic [7:0] r_in, g_in, b_in, input logic eof);
    logic [7:0] r, g, b;
    int         fx, fy, nbytes, line_bytes, next_col, next_row;
    longint     addr;
    fb_write_t  w;
    r  = r_in;
    g  = (color_mode == COLOR_GRAY) ? r_in : g_in;
    b  = (color_mode == COLOR_GRAY) ? r_in : b_in;
    fx = int'($signed(x_offset)) + int'(column);
    fy = int'($signed(y_offset)) + int'(row_idx);
    if (fx >= 0 && fy >= 0 && fx < int'(fb_width) && fy < int'(fb_height) &&
        depth_mode != DEPTH_NONE) begin
      case (depth_mode)
        DEPTH_16: begin
          nbytes = 2;
          w.pixel_word = {16'h0000, r[7:3], g[7:2], b[7:3]};
        end
        DEPTH_24: begin
          nbytes = 3;
          w.pixel_word = {8'h00, r, g, b};
        end
        default: begin
          nbytes = 4;
          w.pixel_word = {8'hFF, r, g, b};
        end
      endcase
      line_bytes = (int'(line_length) > MAX_LINE_BYTES_DEF) ? MAX_LINE_BYTES_DEF
                                                             : int'(line_length);
      addr = longint'(line_bytes) * fy + longint'(fx) * nbytes;
      w.byte_address = addr[ADDR_W-1:0];
      w.byte_count   = COUNT_W'(nbytes);
      expected_writes.push_back(w);
    end
    if (eof) begin
      column  = '0;
      row_idx = '0;
    end else begin
      next_col = int'(column) + 1;
      if (next_col >= int'(src_width) || next_col >= MAX_DIM_DEF) begin
        column   = '0;
        next_row = int'(row_idx) + 1;
        row_idx  = (next_row >= MAX_DIM_DEF) ? '0 : 12'(next_row);
      end else begin
        column = 12'(next_col);
      end
    end
  endfunction

  always @(posedge clk) begin
    fb_write_t want;
    if (rst) begin
      fb_width    = FB_WIDTH_RST;
      fb_height   = FB_HEIGHT_RST;
      line_length = LINE_LENGTH_RST;
      depth_mode  = DEPTH_MODE_RST;
      x_offset    = '0;
      y_offset    = '0;
      src_width   = SRC_WIDTH_RST;
      color_mode  = COLOR_MODE_RST;
      column      = '0;
      row_idx     = '0;
      expected_writes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_writes.size() == 0) begin
          error_total++;
          $error("unexpected write transfer: byte_address %h, pixel_word %h",
                 m_tdata[25:0], m_tdata[57:26]);
        end else begin
          want = expected_writes.pop_front();
          checked_total++;
          if (m_tdata[25:0] !== want.byte_address) begin
            error_total++;
            $error("byte_address mismatch: expected %h, actual %h",
                   want.byte_address, m_tdata[25:0]);
          end
          if (m_tdata[57:26] !== want.pixel_word) begin
            error_total++;
            $error("pixel_word mismatch: expected %h, actual %h",
                   want.pixel_word, m_tdata[57:26]);
          end
          if (m_tdata[60:58] !== want.byte_count) begin
            error_total++;
            $error("byte_count mismatch: expected %0d, actual %0d",
                   want.byte_count, m_tdata[60:58]);
          end
        end
      end
      if (s_tvalid && s_tready)
        place_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast);
      if (cfg_we) begin
        case (cfg_index)
          REG_FB_WIDTH:    fb_width    = cfg_data[FB_DIM_W-1:0];
          REG_FB_HEIGHT:   fb_height   = cfg_data[FB_DIM_W-1:0];
          REG_LINE_LENGTH: line_length = cfg_data[LINE_W-1:0];
          REG_DEPTH_MODE:  depth_mode  = cfg_data[1:0];
          REG_X_OFFSET:    x_offset    = cfg_data[FB_DIM_W-1:0];
          REG_Y_OFFSET:    y_offset    = cfg_data[FB_DIM_W-1:0];
          REG_SRC_WIDTH:   src_width   = cfg_data[FB_DIM_W-1:0];
          REG_COLOR_MODE:  color_mode  = cfg_data[0];
          default: ;
        endcase
      end
    end
    mismatches     <= error_total;
    pending        <= expected_writes.size();
    writes_checked <= checked_total;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Top of the clipped pixel blit testbench: clock, reset, configuration and pixel stimulus.
// Depends on cpb_pkg, cpb_checker and clipped_pixel_blit_format_convert_core.
module tb;
  import cpb_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    logic [FB_DIM_W-1:0] fb_width;
    logic [FB_DIM_W-1:0] fb_height;
    logic [LINE_W-1:0]   line_length;
    logic [1:0]          depth_mode;
    logic [FB_DIM_W-1:0] x_offset;
    logic [FB_DIM_W-1:0] y_offset;
    logic [FB_DIM_W-1:0] src_width;
    logic                color_mode;
  } blit_setting_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata = '0;   // red, green, blue
  logic                  s_tlast = 1'b0; // end_of_frame
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;        // byte_address, pixel_word, byte_count

  int mismatches, pending, writes_checked;
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_applied = 0;
  int ready_run = 0;
  int ready_mode = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  clipped_pixel_blit_format_convert_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  cpb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .pending        (pending),
    .writes_checked (writes_checked)
  );

  // Receiver: runs of always-ready, coin-flip, mostly-stalled and fully stalled.
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_run  = $urandom_range(1, 24);
      ready_mode = $urandom_range(0, 3);
    end
    ready_run--;
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic blit_setting_t blit_setting(input int fbw, fbh, line_bytes,
                                                 input logic [1:0] depth,
                                                 input int xoff, yoff, srcw,
                                                 input logic color);
    blit_setting_t st;
    st.fb_width    = FB_DIM_W'(fbw);
    st.fb_height   = FB_DIM_W'(fbh);
    st.line_length = LINE_W'(line_bytes);
    st.depth_mode  = depth;
    st.x_offset    = FB_DIM_W'(xoff);
    st.y_offset    = FB_DIM_W'(yoff);
    st.src_width   = FB_DIM_W'(srcw);
    st.color_mode  = color;
    return st;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 4096;
      2:       return 8191;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0:       return -4096;
      1:       return 4095;
      default: return $urandom_range(0, 48) - 16;
    endcase
  endfunction

  function automatic blit_setting_t random_setting();
    int         line_bytes, srcw;
    logic [1:0] depth;
    case ($urandom_range(0, 5))
      0:       line_bytes = 32767;
      1:       line_bytes = 16384;
      2:       line_bytes = $urandom_range(16385, 32767);
      default: line_bytes = $urandom_range(1, 200);
    endcase
    case ($urandom_range(0, 6))
      0, 1:    depth = DEPTH_16;
      2, 3:    depth = DEPTH_24;
      4, 5:    depth = DEPTH_32;
      default: depth = DEPTH_NONE;
    endcase
    case ($urandom_range(0, 9))
      0:       srcw = 0;
      1:       srcw = 4096;
      2:       srcw = 8191;
      default: srcw = $urandom_range(1, 24);
    endcase
    return blit_setting(pick_dim(), pick_dim(), line_bytes, depth, pick_offset(),
                        pick_offset(), srcw, $urandom_range(0, 1) ? COLOR_RGB : COLOR_GRAY);
  endfunction

  // Stop the stream and wait until every predicted write has come out.
  task automatic drain();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input blit_setting_t st);
    drain();
    put_reg(REG_FB_WIDTH,    CFG_DATA_W'(st.fb_width));
    put_reg(REG_FB_HEIGHT,   CFG_DATA_W'(st.fb_height));
    put_reg(REG_LINE_LENGTH, CFG_DATA_W'(st.line_length));
    put_reg(REG_DEPTH_MODE,  CFG_DATA_W'(st.depth_mode));
    put_reg(REG_X_OFFSET,    CFG_DATA_W'(st.x_offset));
    put_reg(REG_Y_OFFSET,    CFG_DATA_W'(st.y_offset));
    put_reg(REG_SRC_WIDTH,   CFG_DATA_W'(st.src_width));
    put_reg(REG_COLOR_MODE,  CFG_DATA_W'(st.color_mode));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Drive one pixel; bursts of random length are separated by random gaps.
  task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic send_random_pixel(input logic last);
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), last);
  endtask

  task automatic send_frame(input int cols, input int rows);
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < cols; x++)
        send_random_pixel(y == rows - 1 && x == cols - 1);
  endtask

  initial begin
    blit_setting_t st;
    int            phase_start, frame_cols;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: 32 bpp RGB at the origin
    send_pixel(8'hFF, 8'h00, 8'h80, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h7F, 1'b0);
    send_pixel(8'hA5, 8'h5A, 8'hC3, 1'b1);

    // RGB565, image shifted up-left so the first row and column clip away
    apply_setting(blit_setting(4, 4, 8, DEPTH_16, -1, -1, 3, COLOR_RGB));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hF8, 8'hFC, 8'hF8, 1'b0);
    send_pixel(8'h07, 8'h03, 8'h07, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h80, 8'h40, 8'h20, 1'b0);
    send_pixel(8'h01, 8'h02, 8'h04, 1'b1);

    // 24 bpp gray with a zero source width: one pixel per row
    apply_setting(blit_setting(3, 2, 16, DEPTH_24, 2, 0, 0, COLOR_GRAY));
    send_pixel(8'h80, 8'h11, 8'h22, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);

    // Unsupported depth, then zero framebuffer width and height: all dropped
    apply_setting(blit_setting(640, 480, 2560, DEPTH_NONE, 0, 0, 640, COLOR_RGB));
    send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    apply_setting(blit_setting(0, 480, 2560, DEPTH_32, 0, 0, 640, COLOR_RGB));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    apply_setting(blit_setting(640, 0, 2560, DEPTH_32, 0, 0, 640, COLOR_RGB));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // Saturated line length at the far corner: the second address wraps past 2^26
    apply_setting(blit_setting(8191, 8191, 32767, DEPTH_32, 4095, 4095, 8191, COLOR_RGB));
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'hC3, 8'h3C, 8'h81, 1'b1);

    // Random settings: mostly whole frames, some loose pixels with stray frame ends
    for (int phase = 0; phase < 10; phase++) begin
      st = random_setting();
      apply_setting(st);
      phase_start = pixels_sent;
      frame_cols  = (st.src_width == 0) ? 1 : int'(st.src_width);
      while (pixels_sent - phase_start < 40) begin
        if (frame_cols <= 24 && $urandom_range(0, 4) != 0)
          send_frame(frame_cols, $urandom_range(1, 6));
        else
          repeat ($urandom_range(1, 10)) send_random_pixel($urandom_range(0, 15) == 0);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("%0d pixels streamed under %0d register settings, %0d framebuffer writes checked",
             pixels_sent, settings_applied, writes_checked);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
